FILE: rtl/core/ppu_sat_pkg.sv
// ----------------------------------------------------------------------------
// ppu_sat_pkg
// shared types, command codes and timing constants of the scroll/address unit
// ----------------------------------------------------------------------------
package ppu_sat_pkg;

    localparam int DOTS_PER_LINE   = 341;
    localparam int LINES_PER_FRAME = 262;

    localparam logic [2:0] CMD_CTRL   = 3'd0;
    localparam logic [2:0] CMD_SCROLL = 3'd1;
    localparam logic [2:0] CMD_ADDR   = 3'd2;
    localparam logic [2:0] CMD_STATUS = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;

    localparam logic [8:0] LINE_VISIBLE_END = 9'd240;
    localparam logic [8:0] LINE_VBLANK      = 9'd241;
    localparam logic [8:0] LINE_PRERENDER   = 9'd261;

    localparam logic [8:0] DOT_FIRST      = 9'd1;
    localparam logic [8:0] DOT_Y_STEP     = 9'd256;
    localparam logic [8:0] DOT_HORIZ_COPY = 9'd257;
    localparam logic [8:0] DOT_VERT_FIRST = 9'd280;
    localparam logic [8:0] DOT_VERT_LAST  = 9'd304;
    localparam logic [8:0] DOT_PREFETCH   = 9'd328;

    localparam logic [14:0] HORIZ_BITS = 15'h041F;
    localparam logic [14:0] VERT_BITS  = 15'h7BE0;
    localparam logic [13:0] TILE_BASE  = 14'h2000;
    localparam logic [13:0] ATTR_BASE  = 14'h23C0;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 88;

    typedef struct packed {
        logic [14:0] cur_addr;
        logic [14:0] tmp_addr;
        logic [2:0]  fine_x;
        logic        toggle;
        logic [8:0]  line_count;
        logic [8:0]  dot_count;
        logic        vblank;
    } sat_state_t;

    typedef struct packed {
        logic        fetch_valid;
        logic [13:0] tile_address;
        logic [13:0] attribute_address;
        logic [2:0]  attribute_shift;
    } sat_fetch_t;

endpackage

FILE: rtl/core/ppu_scroll_address_timing.sv
// ----------------------------------------------------------------------------
// ppu_scroll_address_timing
// scroll/address registers with dot and line timing of the video chip
// ----------------------------------------------------------------------------
// a request is held in the input register, its result in the result register
// throughput: one request per cycle while m_tready holds (single-pass state update)
// an empty input stage takes a new request while a result waits on m_tready
// reset: asynchronous, clears all state, line counter starts at the pre-render line
// ----------------------------------------------------------------------------
module ppu_scroll_address_timing (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ppu_sat_pkg::S_TDATA_W-1:0]  s_tdata,   // value
    input  logic [ppu_sat_pkg::S_TUSER_W-1:0]  s_tuser,   // command, peek
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // current_address, temp_address, fine_scroll_x, write_toggle, vblank_flag,
    // fetch_valid, tile_address, attribute_address, attribute_shift,
    // line_number, dot_number, zero fill
    output logic [ppu_sat_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ppu_sat_pkg::*;

    logic                 in_valid_reg;
    logic [2:0]           command_reg;
    logic [7:0]           value_reg;
    logic                 peek_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    sat_state_t           state_reg;
    sat_state_t           state_next;
    sat_fetch_t           fetch;
    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    ppu_sat_step u_step (
        .state      (state_reg),
        .command    (command_reg),
        .value      (value_reg),
        .peek       (peek_reg),
        .state_next (state_next),
        .fetch      (fetch)
    );

    assign out_data_next = {3'b000,
                            state_next.dot_count,
                            state_next.line_count,
                            fetch.attribute_shift,
                            fetch.attribute_address,
                            fetch.tile_address,
                            fetch.fetch_valid,
                            state_reg.vblank,
                            state_next.toggle,
                            state_next.fine_x,
                            state_next.tmp_addr,
                            state_next.cur_addr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{cur_addr: 15'd0, tmp_addr: 15'd0, fine_x: 3'd0,
                               toggle: 1'b0, line_count: LINE_PRERENDER,
                               dot_count: 9'd0, vblank: 1'b0};
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            command_reg <= s_tuser[2:0];
            peek_reg    <= s_tuser[3];
            value_reg   <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

FILE: rtl/core/ppu_sat_step.sv
// ----------------------------------------------------------------------------
// ppu_sat_step
// next-state and fetch logic for one command applied to the scroll state
// ----------------------------------------------------------------------------
module ppu_sat_step (
    input  ppu_sat_pkg::sat_state_t state,
    input  logic [2:0]              command,
    input  logic [7:0]              value,
    input  logic                    peek,
    output ppu_sat_pkg::sat_state_t state_next,
    output ppu_sat_pkg::sat_fetch_t fetch
);
    import ppu_sat_pkg::*;

    function automatic logic [14:0] step_coarse_x(input logic [14:0] a);
        logic [14:0] r;
        begin
            r = a;
            if (a[4:0] == 5'd31)
            begin
                r[4:0] = 5'd0;
                r[10]  = ~a[10];
            end
            else
            begin
                r[4:0] = a[4:0] + 5'd1;
            end
            return r;
        end
    endfunction

    function automatic logic [14:0] step_y(input logic [14:0] a);
        logic [14:0] r;
        begin
            r = a;
            if (a[14:12] != 3'd7)
            begin
                r[14:12] = a[14:12] + 3'd1;
            end
            else
            begin
                r[14:12] = 3'd0;
                if (a[9:5] == 5'd29)
                begin
                    r[9:5] = 5'd0;
                    r[11]  = ~a[11];
                end
                else if (a[9:5] == 5'd31)
                begin
                    r[9:5] = 5'd0;
                end
                else
                begin
                    r[9:5] = a[9:5] + 5'd1;
                end
            end
            return r;
        end
    endfunction

    logic       render;
    logic       prerender;
    logic       fetch_dot;
    logic [9:0] dot_inc;
    logic [9:0] line_inc;

    assign prerender = (state.line_count == LINE_PRERENDER);
    assign render    = (state.line_count < LINE_VISIBLE_END) || prerender;
    assign fetch_dot = (state.dot_count != 9'd0) && (state.dot_count[2:0] == 3'd0)
                       && ((state.dot_count <= DOT_Y_STEP) || (state.dot_count >= DOT_PREFETCH));
    assign dot_inc   = {1'b0, state.dot_count} + 10'd1;
    assign line_inc  = {1'b0, state.line_count} + 10'd1;

    always_comb
    begin
        state_next = state;
        fetch      = '0;
        case (command)
            CMD_CTRL:
            begin
                state_next.tmp_addr[11:10] = value[1:0];
            end
            CMD_SCROLL:
            begin
                if (!state.toggle)
                begin
                    state_next.tmp_addr[4:0] = value[7:3];
                    state_next.fine_x        = value[2:0];
                end
                else
                begin
                    state_next.tmp_addr[14:12] = value[2:0];
                    state_next.tmp_addr[9:5]   = value[7:3];
                end
                state_next.toggle = ~state.toggle;
            end
            CMD_ADDR:
            begin
                if (!state.toggle)
                begin
                    state_next.tmp_addr[13:8] = value[5:0];
                    state_next.tmp_addr[14]   = 1'b0;
                end
                else
                begin
                    state_next.tmp_addr[7:0] = value;
                    state_next.cur_addr      = {state.tmp_addr[14:8], value};
                end
                state_next.toggle = ~state.toggle;
            end
            CMD_STATUS:
            begin
                if (!peek)
                begin
                    state_next.vblank = 1'b0;
                    state_next.toggle = 1'b0;
                end
            end
            CMD_TICK:
            begin
                if (render)
                begin
                    if (fetch_dot)
                    begin
                        fetch.fetch_valid       = 1'b1;
                        fetch.tile_address      = TILE_BASE | {2'b00, state.cur_addr[11:0]};
                        fetch.attribute_address = ATTR_BASE
                            | {2'b00, state.cur_addr[11:10], 4'd0, state.cur_addr[9:7],
                               state.cur_addr[4:2]};
                        fetch.attribute_shift   = {state.cur_addr[6], state.cur_addr[1], 1'b0};
                        if (state.dot_count == DOT_Y_STEP)
                        begin
                            state_next.cur_addr = step_y(step_coarse_x(state.cur_addr));
                        end
                        else
                        begin
                            state_next.cur_addr = step_coarse_x(state.cur_addr);
                        end
                    end
                    else if (state.dot_count == DOT_HORIZ_COPY)
                    begin
                        state_next.cur_addr = (state.cur_addr & ~HORIZ_BITS)
                                              | (state.tmp_addr & HORIZ_BITS);
                    end
                    else if (prerender && (state.dot_count >= DOT_VERT_FIRST)
                             && (state.dot_count <= DOT_VERT_LAST))
                    begin
                        state_next.cur_addr = (state.cur_addr & ~VERT_BITS)
                                              | (state.tmp_addr & VERT_BITS);
                    end
                    if (prerender && (state.dot_count == DOT_FIRST))
                    begin
                        state_next.vblank = 1'b0;
                    end
                end
                else if ((state.line_count == LINE_VBLANK) && (state.dot_count == DOT_FIRST))
                begin
                    state_next.vblank = 1'b1;
                end
                if ((dot_inc >= 10'(DOTS_PER_LINE)) || dot_inc[9])
                begin
                    state_next.dot_count = 9'd0;
                    if ((line_inc >= 10'(LINES_PER_FRAME)) || line_inc[9])
                    begin
                        state_next.line_count = 9'd0;
                    end
                    else
                    begin
                        state_next.line_count = line_inc[8:0];
                    end
                end
                else
                begin
                    state_next.dot_count = dot_inc[8:0];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/core/ppu_sat_check.sv
// ----------------------------------------------------------------------------
// ppu_sat_check
// port-level checks of the scroll/address unit, bound to the top level
// ----------------------------------------------------------------------------
module ppu_sat_check (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ppu_sat_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ppu_sat_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input stalls only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // no fetch means zero fetch fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[35] |-> m_tdata[66:36] == 31'd0)
        else $error("fetch fields set without fetch");

    // fetch addresses stay in name and attribute table space
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[35] |-> m_tdata[49:48] == 2'b10 && m_tdata[63:62] == 2'b10
            && m_tdata[59:56] == 4'hF && m_tdata[64] == 1'b0)
        else $error("fetch address out of table space");

    // counters stay inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[84:76] < 9'(DOTS_PER_LINE) && m_tdata[75:67] < 9'(LINES_PER_FRAME))
        else $error("dot or line counter out of range");

endmodule

bind ppu_scroll_address_timing ppu_sat_check u_sat_check (.*);

FILE: sim/ppu_scroll_address_timing_tb.sv
// ----------------------------------------------------------------------------
// ppu_scroll_address_timing_tb
// Self-checking bench for the scroll/address unit. A short directed sequence
// covers register write corners, status reads and peeks, the unused command
// codes and the first tile fetch. A random mix of register traffic and dot
// ticks follows, with random gaps and stalls on both streams; starting on the
// pre-render line it reaches the vertical copy and the frame wrap. A final run
// of gap-free ticks with rare register traffic covers one whole line at full rate.
// Every result is compared field by field against an in-bench model of the unit.
// ----------------------------------------------------------------------------
module ppu_scroll_address_timing_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ppu_sat_pkg::*;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int SWEEP_TICKS   = DOTS_PER_LINE;
    localparam int DRAIN_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_PRINTED   = 100;

    // packed to match m_tdata, first field in the highest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [8:0]  dot_number;
        logic [8:0]  line_number;
        logic [2:0]  attribute_shift;
        logic [13:0] attribute_address;
        logic [13:0] tile_address;
        logic        fetch_valid;
        logic        vblank_flag;
        logic        write_toggle;
        logic [2:0]  fine_scroll_x;
        logic [14:0] temp_address;
        logic [14:0] current_address;
    } scroll_result_t;

    class scroll_timing_scoreboard;
        logic [14:0]    cur_addr;
        logic [14:0]    tmp_addr;
        logic [2:0]     fine_x;
        logic           toggle;
        logic [8:0]     line_cnt;
        logic [8:0]     dot_cnt;
        logic           vblank;
        scroll_result_t expected_q[$];
        int             errors;

        function new();
            cur_addr = '0;
            tmp_addr = '0;
            fine_x   = '0;
            toggle   = 1'b0;
            line_cnt = LINE_PRERENDER;
            dot_cnt  = '0;
            vblank   = 1'b0;
            errors   = 0;
        endfunction

        function void step_coarse_x();
            if (cur_addr[4:0] == 5'd31)
            begin
                cur_addr[4:0] = 5'd0;
                cur_addr[10]  = ~cur_addr[10];
            end
            else
                cur_addr = cur_addr + 15'd1;
        endfunction

        function void step_fine_y();
            logic [4:0] row;
            if (cur_addr[14:12] != 3'd7)
                cur_addr[14:12] = cur_addr[14:12] + 3'd1;
            else
            begin
                cur_addr[14:12] = 3'd0;
                row = cur_addr[9:5];
                if (row == 5'd29)
                begin
                    row = 5'd0;
                    cur_addr[11] = ~cur_addr[11];
                end
                else if (row == 5'd31)
                    row = 5'd0;
                else
                    row = row + 5'd1;
                cur_addr[9:5] = row;
            end
        endfunction

        function void advance_dot(ref scroll_result_t r);
            logic [8:0] dot;
            bit         rendering;
            dot = dot_cnt;
            rendering = (line_cnt < LINE_VISIBLE_END) || (line_cnt == LINE_PRERENDER);
            if (rendering)
            begin
                if (dot != 0 && dot[2:0] == 3'd0 && (dot <= DOT_Y_STEP || dot >= DOT_PREFETCH))
                begin
                    r.fetch_valid       = 1'b1;
                    r.tile_address      = TILE_BASE | {2'b00, cur_addr[11:0]};
                    r.attribute_address = ATTR_BASE | {2'b00, cur_addr[11:10], 4'b0000,
                                                       cur_addr[9:7], cur_addr[4:2]};
                    r.attribute_shift   = {cur_addr[6], cur_addr[1], 1'b0};
                    step_coarse_x();
                    if (dot == DOT_Y_STEP)
                        step_fine_y();
                end
                else if (dot == DOT_HORIZ_COPY)
                    cur_addr = (cur_addr & ~HORIZ_BITS) | (tmp_addr & HORIZ_BITS);
                else if (line_cnt == LINE_PRERENDER && dot >= DOT_VERT_FIRST
                         && dot <= DOT_VERT_LAST)
                    cur_addr = (cur_addr & ~VERT_BITS) | (tmp_addr & VERT_BITS);
                if (line_cnt == LINE_PRERENDER && dot == DOT_FIRST)
                    vblank = 1'b0;
            end
            else if (line_cnt == LINE_VBLANK && dot == DOT_FIRST)
                vblank = 1'b1;
            if (int'(dot) + 1 >= DOTS_PER_LINE)
            begin
                dot_cnt = '0;
                if (int'(line_cnt) + 1 >= LINES_PER_FRAME)
                    line_cnt = '0;
                else
                    line_cnt = line_cnt + 9'd1;
            end
            else
                dot_cnt = dot + 9'd1;
        endfunction

        function void note_request(logic [2:0] cmd, logic [7:0] val, logic pk);
            scroll_result_t r;
            r = '0;
            r.vblank_flag = vblank;
            case (cmd)
                CMD_CTRL:
                    tmp_addr[11:10] = val[1:0];
                CMD_SCROLL:
                begin
                    if (!toggle)
                    begin
                        tmp_addr[4:0] = val[7:3];
                        fine_x        = val[2:0];
                    end
                    else
                    begin
                        tmp_addr[14:12] = val[2:0];
                        tmp_addr[9:5]   = val[7:3];
                    end
                    toggle = ~toggle;
                end
                CMD_ADDR:
                begin
                    if (!toggle)
                    begin
                        tmp_addr[13:8] = val[5:0];
                        tmp_addr[14]   = 1'b0;
                    end
                    else
                    begin
                        tmp_addr[7:0] = val;
                        cur_addr      = tmp_addr;
                    end
                    toggle = ~toggle;
                end
                CMD_STATUS:
                    if (!pk)
                    begin
                        vblank = 1'b0;
                        toggle = 1'b0;
                    end
                CMD_TICK:
                    advance_dot(r);
                default: ;
            endcase
            r.current_address = cur_addr;
            r.temp_address    = tmp_addr;
            r.fine_scroll_x   = fine_x;
            r.write_toggle    = toggle;
            r.line_number     = line_cnt;
            r.dot_number      = dot_cnt;
            expected_q = {expected_q, r};
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        endtask

        task check_result(logic [M_TDATA_W-1:0] data);
            scroll_result_t got;
            scroll_result_t want;
            got = data;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with no request pending");
                return;
            end
            want = expected_q.pop_front();
            compare_field("current_address", got.current_address, want.current_address);
            compare_field("temp_address", got.temp_address, want.temp_address);
            compare_field("fine_scroll_x", got.fine_scroll_x, want.fine_scroll_x);
            compare_field("write_toggle", got.write_toggle, want.write_toggle);
            compare_field("vblank_flag", got.vblank_flag, want.vblank_flag);
            compare_field("fetch_valid", got.fetch_valid, want.fetch_valid);
            compare_field("tile_address", got.tile_address, want.tile_address);
            compare_field("attribute_address", got.attribute_address,
                          want.attribute_address);
            compare_field("attribute_shift", got.attribute_shift, want.attribute_shift);
            compare_field("line_number", got.line_number, want.line_number);
            compare_field("dot_number", got.dot_number, want.dot_number);
        endtask
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    scroll_timing_scoreboard sb = new();
    int requests_sent = 0;
    int cycle_count   = 0;
    bit sweep_on      = 1'b0;
    bit burst_s       = 1'b0;
    bit burst_m       = 1'b0;

    ppu_scroll_address_timing dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_request(s_tuser[2:0], s_tdata, s_tuser[3]);
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    task automatic send_request(logic [2:0] cmd, logic [7:0] val, logic pk);
        int gap;
        gap = (sweep_on || burst_s) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= {pk, cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_tick();
        send_request(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_register_traffic();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            // status read to reset the toggle, then a full address load
            send_request(CMD_STATUS, 8'($urandom), 1'b0);
            send_request(CMD_ADDR, 8'($urandom), 1'($urandom));
            send_request(CMD_ADDR, 8'($urandom), 1'($urandom));
        end
        else if (pick < 35)
        begin
            send_request(CMD_STATUS, 8'($urandom), 1'b0);
            send_request(CMD_SCROLL, 8'($urandom), 1'($urandom));
            send_request(CMD_SCROLL, 8'($urandom), 1'($urandom));
        end
        else if (pick < 47)
            send_request(CMD_CTRL, 8'($urandom), 1'($urandom));
        else if (pick < 59)
            send_request(CMD_SCROLL, 8'($urandom), 1'($urandom));
        else if (pick < 71)
            send_request(CMD_ADDR, 8'($urandom), 1'($urandom));
        else if (pick < 90)
            send_request(CMD_STATUS, 8'($urandom), 1'($urandom));
        else
            send_request(3'($urandom_range(int'(CMD_UNUSED_LO), int'(CMD_UNUSED_HI))),
                         8'($urandom), 1'($urandom));
    endtask

    initial
    begin
        int stall;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                burst_m = ~burst_m;
            stall = (sweep_on || burst_m) ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_TICK, 8'h00, 1'b0);
        send_request(CMD_CTRL, 8'hFF, 1'b1);
        send_request(CMD_CTRL, 8'h00, 1'b0);
        send_request(CMD_SCROLL, 8'hFF, 1'b0);
        send_request(CMD_SCROLL, 8'hFF, 1'b0);
        // first address write must drop the top fine-y bit
        send_request(CMD_ADDR, 8'hFF, 1'b0);
        send_request(CMD_ADDR, 8'h00, 1'b0);
        send_request(CMD_STATUS, 8'hFF, 1'b1);
        send_request(CMD_SCROLL, 8'h00, 1'b1);
        send_request(CMD_STATUS, 8'h00, 1'b0);
        send_request(CMD_SCROLL, 8'h00, 1'b0);
        send_request(CMD_SCROLL, 8'h00, 1'b0);
        send_request(CMD_ADDR, 8'h3F, 1'b0);
        send_request(CMD_ADDR, 8'hFF, 1'b0);
        for (int c = int'(CMD_UNUSED_LO); c <= int'(CMD_UNUSED_HI); c++)
            send_request(3'(c), 8'hFF, 1'b1);
        send_request(CMD_CTRL, 8'h02, 1'b0);
        // first fetch of the pre-render line, coarse x wraps into the next table
        repeat (8) send_tick();

        while (requests_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
                burst_s = ~burst_s;
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 8)) send_tick();
            else
                send_register_traffic();
        end

        // full line without gaps, with sparse register traffic
        sweep_on = 1'b1;
        repeat (SWEEP_TICKS)
        begin
            send_tick();
            if ($urandom_range(0, 399) == 0)
                send_register_traffic();
        end
        sweep_on = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ppu_sat_pkg.sv
rtl/core/ppu_sat_step.sv
rtl/core/ppu_scroll_address_timing.sv
rtl/core/ppu_sat_check.sv
sim/ppu_scroll_address_timing_tb.sv
